// File: rtl/v2d_pkg.sv
// ----------------------------------------------------------------------------
// v2d_pkg
// Shared constants and helpers for the 2D vector rotate/scale/heading unit.
// ----------------------------------------------------------------------------
package v2d_pkg;

  localparam int COORD_W      = 32;
  localparam int ANGLE_W      = 16;
  localparam int LEN_W        = 31;
  localparam int EXT_W        = 52;   // CORDIC datapath, 16 guard bits plus growth
  localparam int Z_W          = 36;   // angle accumulator, Q2.30 plus headroom
  localparam int CORDIC_STEPS = 16;

  localparam logic [2:0] F_LOAD   = 3'd0;
  localparam logic [2:0] F_LOADS  = 3'd1;
  localparam logic [2:0] F_ROTATE = 3'd2;
  localparam logic [2:0] F_SETLEN = 3'd3;
  localparam logic [2:0] F_ANGLE  = 3'd4;

  localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic [31:0]           GAIN_Q31    = 32'd1304065748;

  typedef logic signed [EXT_W-1:0] ext_t;
  typedef logic signed [Z_W-1:0]   zang_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Arctangent of 2^-i in Q2.30.
  function automatic zang_t atan_q30(input logic [4:0] i);
    zang_t r;
    unique case (i)
      5'd0:  r = 36'sh03243F6A9;
      5'd1:  r = 36'sh01DAC6705;
      5'd2:  r = 36'sh00FADBAFD;
      5'd3:  r = 36'sh007F56EA7;
      5'd4:  r = 36'sh003FEAB77;
      5'd5:  r = 36'sh001FFD55C;
      5'd6:  r = 36'sh000FFFAAB;
      5'd7:  r = 36'sh0007FFF55;
      5'd8:  r = 36'sh0003FFFEB;
      5'd9:  r = 36'sh0001FFFFD;
      5'd10: r = 36'sh000100000;
      5'd11: r = 36'sh000080000;
      5'd12: r = 36'sh000040000;
      5'd13: r = 36'sh000020000;
      5'd14: r = 36'sh000010000;
      5'd15: r = 36'sh000008000;
      5'd16: r = 36'sh000004000;
      5'd17: r = 36'sh000002000;
      5'd18: r = 36'sh000001000;
      5'd19: r = 36'sh000000800;
      5'd20: r = 36'sh000000400;
      5'd21: r = 36'sh000000200;
      5'd22: r = 36'sh000000100;
      5'd23: r = 36'sh000000080;
      5'd24: r = 36'sh000000040;
      5'd25: r = 36'sh000000020;
      5'd26: r = 36'sh000000010;
      5'd27: r = 36'sh000000008;
      5'd28: r = 36'sh000000004;
      5'd29: r = 36'sh000000002;
      5'd30: r = 36'sh000000001;
      5'd31: r = 36'sh000000000;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/vector_2d_rotate_scale_heading.sv
// ----------------------------------------------------------------------------
// vector_2d_rotate_scale_heading
// Holds one Q16.16 vector and loads, rotates, rescales or measures it.
// ----------------------------------------------------------------------------
// One request at a time: in_ready is high only while the unit is idle, and a
// finished result sits in the output register until taken, so the next
// request can enter meanwhile. Every request ends with a length pass (two
// squarings on one 32x32 multiplier, then a radix-4 square root, two bits
// of radicand per cycle) and a 16-iteration CORDIC heading. Rotate adds a
// gain multiply, an angle reduction and 16 CORDIC steps. Load-scaled and
// set-length add a length pass plus two restoring divisions, one quotient
// bit per cycle. Angle-to-input adds one heading, of the input vector.
// The heading is taken from +y counterclockwise in Q4.12 radians; scaling a
// zero-length vector leaves it alone, and rotated coordinates saturate.
// ----------------------------------------------------------------------------
module vector_2d_rotate_scale_heading
  import v2d_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                func,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic [LEN_W-1:0]          target_length,
  input  logic signed [ANGLE_W-1:0] turn_angle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic [COORD_W-1:0]        magnitude,
  output logic signed [ANGLE_W-1:0] angle_out
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQ1   = 5'd1;
  localparam logic [4:0] S_SQ2   = 5'd2;
  localparam logic [4:0] S_SQ3   = 5'd3;
  localparam logic [4:0] S_SQRT  = 5'd4;
  localparam logic [4:0] S_SMUL  = 5'd5;
  localparam logic [4:0] S_SCHK  = 5'd6;
  localparam logic [4:0] S_SDIV  = 5'd7;
  localparam logic [4:0] S_SFIN  = 5'd8;
  localparam logic [4:0] S_RMX   = 5'd9;
  localparam logic [4:0] S_RMY   = 5'd10;
  localparam logic [4:0] S_RMZ   = 5'd11;
  localparam logic [4:0] S_RRED  = 5'd12;
  localparam logic [4:0] S_CORD  = 5'd13;
  localparam logic [4:0] S_RFIN  = 5'd14;
  localparam logic [4:0] S_HINIT = 5'd15;
  localparam logic [4:0] S_HFIN  = 5'd16;
  localparam logic [4:0] S_FINAL = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  localparam logic [5:0] LAST_ROOT = 6'd31;
  localparam logic [5:0] LAST_DIV  = 6'd31;
  localparam logic [5:0] LAST_CORD = 6'(CORDIC_STEPS - 1);

  logic [4:0] state;

  // request fields, held for the whole operation
  logic [2:0]                func_r;
  logic [LEN_W-1:0]          len_r;
  logic signed [ANGLE_W-1:0] turn_r;

  logic signed [COORD_W-1:0] cur_x, cur_y;   // held vector
  logic signed [COORD_W-1:0] sx, sy;         // operand of length/heading pass

  logic        scale_phase;  // length pass feeds a rescale (else the final result)
  logic        head_in;      // heading pass measures the input vector
  logic        comp;         // rescale component: 0 x, 1 y
  logic        rot_mode;     // CORDIC rotation (else vectoring)
  logic        hzero;
  logic        dovf;
  logic [5:0]  cnt;

  logic [63:0] prod;
  logic [63:0] rad;          // radicand, shifted out two bits a cycle
  logic [33:0] rem_s;
  logic [31:0] root;         // length result, also the rescale divisor
  logic [31:0] drem;
  logic [31:0] dq;           // dividend low bits in, quotient bits out

  ext_t  cx, cy;
  zang_t cz;

  logic signed [ANGLE_W-1:0] ang_a, ang_keep;
  logic [COORD_W-1:0]        mag_keep;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = abs32(sx);
    mul_b = abs32(sx);
    unique case (state)
      S_SQ2: begin
        mul_a = abs32(sy);
        mul_b = abs32(sy);
      end
      S_SMUL: begin
        mul_a = comp ? abs32(sy) : abs32(sx);
        mul_b = {1'b0, len_r};
      end
      S_RMX: begin
        mul_a = abs32(cur_x);
        mul_b = GAIN_Q31;
      end
      S_RMY: begin
        mul_a = abs32(cur_y);
        mul_b = GAIN_Q31;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // square root digit step
  logic [35:0] r_try, r_trial;
  logic [33:0] rem_next;
  logic [31:0] root_next;

  always_comb begin
    r_try   = {rem_s, rad[63:62]};
    r_trial = {2'b00, root, 2'b01};
    if (r_try >= r_trial) begin
      rem_next  = 34'(r_try - r_trial);
      root_next = {root[30:0], 1'b1};
    end else begin
      rem_next  = r_try[33:0];
      root_next = {root[30:0], 1'b0};
    end
  end

  // division step
  logic [32:0] d_try;
  assign d_try = {drem, dq[31]};

  // CORDIC step
  ext_t  xsh, ysh, cx_step, cy_step;
  zang_t cz_step, atan_i;

  always_comb begin
    xsh    = cx >>> cnt[4:0];
    ysh    = cy >>> cnt[4:0];
    atan_i = atan_q30(cnt[4:0]);
    if (rot_mode ? !cz[Z_W-1] : cy[EXT_W-1]) begin
      cx_step = cx - ysh;
      cy_step = cy + xsh;
      cz_step = rot_mode ? cz - atan_i : cz - atan_i;
    end else begin
      cx_step = cx + ysh;
      cy_step = cy - xsh;
      cz_step = cz + atan_i;
    end
  end

  // gain-scaled start values for rotation, floor shift to 16 guard bits
  function automatic ext_t gain_fix(input logic [63:0] p, input logic neg);
    logic signed [63:0] sp;
    sp = neg ? -$signed(p) : $signed(p);
    return EXT_W'(sp >>> 15);
  endfunction

  // rotation rounding
  ext_t rx_round, ry_round;
  assign rx_round = cx + ext_t'(32768);
  assign ry_round = cy + ext_t'(32768);

  // heading finish: wrap, clamp, round to Q4.12
  zang_t h0, h1, hr;
  logic signed [ANGLE_W-1:0] hq;

  always_comb begin
    h0 = cz - HALF_PI_Q30;
    if (sx[31]) begin
      h1 = h0[Z_W-1] ? h0 + TWO_PI_Q30 : h0;
      if (h1[Z_W-1]) begin
        h1 = '0;
      end else if (h1 > PI_Q30) begin
        h1 = PI_Q30;
      end
    end else begin
      h1 = h0 + TWO_PI_Q30;
      if (h1 < PI_Q30) begin
        h1 = PI_Q30;
      end else if (h1 > TWO_PI_Q30) begin
        h1 = TWO_PI_Q30;
      end
    end
    hr = h1 + zang_t'(131072);
    hq = hzero ? '0 : hr[33:18];
  end

  // rescale result with sign and saturation
  logic                      sneg;
  logic signed [COORD_W-1:0] sval;

  always_comb begin
    sneg = comp ? sy[31] : sx[31];
    if (!sneg) begin
      sval = (dovf || dq[31]) ? 32'sh7FFFFFFF : $signed(dq);
    end else begin
      sval = (dovf || dq > 32'h80000000) ? 32'sh80000000 : 32'(-$signed(dq));
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cur_x     <= '0;
      cur_y     <= '0;
    end else begin
      // drop a taken result, unless a new one is loaded this cycle
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_r <= func;
            len_r  <= target_length;
            turn_r <= turn_angle;
            unique case (func)
              F_LOAD: begin
                cur_x <= in_x;
                cur_y <= in_y;
                state <= S_FINAL;
              end
              F_LOADS: begin
                cur_x       <= '0;
                cur_y       <= '0;
                sx          <= in_x;
                sy          <= in_y;
                scale_phase <= 1'b1;
                state       <= S_SQ1;
              end
              F_ROTATE: state <= S_RMX;
              F_SETLEN: begin
                sx          <= cur_x;
                sy          <= cur_y;
                scale_phase <= 1'b1;
                state       <= S_SQ1;
              end
              F_ANGLE: begin
                sx      <= in_x;
                sy      <= in_y;
                head_in <= 1'b1;
                state   <= S_HINIT;
              end
              default: state <= S_FINAL;
            endcase
          end
        end
        S_FINAL: begin
          sx          <= cur_x;
          sy          <= cur_y;
          scale_phase <= 1'b0;
          head_in     <= 1'b0;
          state       <= S_SQ1;
        end
        // length pass
        S_SQ1: begin
          prod  <= mul_p;
          state <= S_SQ2;
        end
        S_SQ2: begin
          rad   <= prod;
          prod  <= mul_p;
          state <= S_SQ3;
        end
        S_SQ3: begin
          rad   <= rad + prod;
          rem_s <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          rem_s <= rem_next;
          root  <= root_next;
          rad   <= {rad[61:0], 2'b00};
          cnt   <= cnt + 6'd1;
          if (cnt == LAST_ROOT) begin
            if (scale_phase) begin
              // zero length: leave the vector as it stands
              comp  <= 1'b0;
              state <= (root_next == '0) ? S_FINAL : S_SMUL;
            end else begin
              mag_keep <= root_next;
              state    <= S_HINIT;
            end
          end
        end
        // rescale: |c| * L / m per component
        S_SMUL: begin
          prod  <= mul_p;
          state <= S_SCHK;
        end
        S_SCHK: begin
          cnt  <= '0;
          drem <= prod[63:32];
          dq   <= prod[31:0];
          if (prod[63:32] >= root) begin
            dovf  <= 1'b1;
            state <= S_SFIN;
          end else begin
            dovf  <= 1'b0;
            state <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (d_try >= {1'b0, root}) begin
            drem <= 32'(d_try - {1'b0, root});
            dq   <= {dq[30:0], 1'b1};
          end else begin
            drem <= d_try[31:0];
            dq   <= {dq[30:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == LAST_DIV) begin
            state <= S_SFIN;
          end
        end
        S_SFIN: begin
          if (comp) begin
            cur_y <= sval;
            state <= S_FINAL;
          end else begin
            cur_x <= sval;
            comp  <= 1'b1;
            state <= S_SMUL;
          end
        end
        // rotation
        S_RMX: begin
          prod  <= mul_p;
          state <= S_RMY;
        end
        S_RMY: begin
          cx    <= gain_fix(prod, cur_x[31]);
          prod  <= mul_p;
          state <= S_RMZ;
        end
        S_RMZ: begin
          cy    <= gain_fix(prod, cur_y[31]);
          cz    <= {{2{turn_r[15]}}, turn_r, 18'd0};
          state <= S_RRED;
        end
        S_RRED: begin
          // reduce into (-pi, pi], then fold by a half turn
          if (cz > PI_Q30) begin
            cz <= cz - TWO_PI_Q30;
          end else if (cz <= -PI_Q30) begin
            cz <= cz + TWO_PI_Q30;
          end else begin
            if (cz > HALF_PI_Q30) begin
              cx <= -cx;
              cy <= -cy;
              cz <= cz - PI_Q30;
            end else if (cz < -HALF_PI_Q30) begin
              cx <= -cx;
              cy <= -cy;
              cz <= cz + PI_Q30;
            end
            rot_mode <= 1'b1;
            cnt      <= '0;
            state    <= S_CORD;
          end
        end
        S_CORD: begin
          cx  <= cx_step;
          cy  <= cy_step;
          cz  <= cz_step;
          cnt <= cnt + 6'd1;
          if (cnt == LAST_CORD) begin
            state <= rot_mode ? S_RFIN : S_HFIN;
          end
        end
        S_RFIN: begin
          cur_x <= sat32(rx_round[51:16]);
          cur_y <= sat32(ry_round[51:16]);
          state <= S_FINAL;
        end
        // heading
        S_HINIT: begin
          rot_mode <= 1'b0;
          cnt      <= '0;
          hzero    <= (sx == '0) && (sy == '0);
          if (sx[31]) begin
            cx <= -{{4{sx[31]}}, sx, 16'd0};
            cy <= -{{4{sy[31]}}, sy, 16'd0};
            cz <= sy[31] ? -PI_Q30 : PI_Q30;
          end else begin
            cx <= {{4{sx[31]}}, sx, 16'd0};
            cy <= {{4{sy[31]}}, sy, 16'd0};
            cz <= '0;
          end
          state <= ((sx == '0) && (sy == '0)) ? S_HFIN : S_CORD;
        end
        S_HFIN: begin
          if (head_in) begin
            ang_a <= hq;
            state <= S_FINAL;
          end else begin
            ang_keep <= (func_r == F_ANGLE) ? 16'(ang_a - hq) : hq;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_x     <= cur_x;
            out_y     <= cur_y;
            magnitude <= mag_keep;
            angle_out <= ang_keep;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2D vector rotate/scale/heading unit.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver. A bit-accurate predictor
// updates its own copy of the held vector on every accepted request and pushes
// the expected result. A clocked monitor compares each accepted result with
// the oldest expectation. The run is a directed opener followed by four random
// phases with different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import v2d_pkg::*;

  // Codes the package leaves unnamed: query, and the two spare codes.
  localparam logic [2:0] F_QUERY  = 3'd5;
  localparam logic [2:0] F_SPARE6 = 3'd6;
  localparam logic [2:0] F_SPARE7 = 3'd7;

  localparam longint PI_Z      = 64'sd3373259426;
  localparam longint HALF_PI_Z = 64'sd1686629713;
  localparam longint TWO_PI_Z  = 64'sd6746518852;
  localparam longint GAIN_Z    = 64'sd1304065748;
  localparam int     WATCHDOG_LIMIT = 20000;
  localparam int     RANDOM_PER_PHASE = 380;

  localparam longint ARCTAN_Z [16] = '{
    64'h3243F6A9, 64'h1DAC6705, 64'h0FADBAFD, 64'h07F56EA7,
    64'h03FEAB77, 64'h01FFD55C, 64'h00FFFAAB, 64'h007FFF55,
    64'h003FFFEB, 64'h001FFFFD, 64'h00100000, 64'h00080000,
    64'h00040000, 64'h00020000, 64'h00010000, 64'h00008000};

  typedef struct packed {
    logic [2:0]          op;
    logic signed [31:0]  vx;
    logic signed [31:0]  vy;
    logic [LEN_W-1:0]    len;
    logic signed [15:0]  turn;
  } vec_request_t;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] mag;
    logic [15:0] heading;
  } vec_result_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [2:0]                func;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;
  logic [LEN_W-1:0]          target_length;
  logic signed [ANGLE_W-1:0] turn_angle;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic [COORD_W-1:0]        magnitude;
  logic signed [ANGLE_W-1:0] angle_out;

  vector_2d_rotate_scale_heading dut (.*);

  vec_request_t pending_requests[$];
  vec_result_t  expected_results[$];
  longint       held_x, held_y;        // predictor's copy of the held vector
  int           sender_idle_pct, receiver_stall_pct;
  logic         request_taken;
  int           error_count, result_count, quiet_cycles;
  int           op_count [8];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint sat_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= root + bit_w) begin
        n -= root + bit_w;
        root = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned vec_length(longint x, longint y);
    longint unsigned ax, ay, m;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    m = int_sqrt(ax * ax + ay * ay);
    return (m > 64'hFFFFFFFF) ? 64'hFFFFFFFF : m;
  endfunction

  // Heading from +y counterclockwise, rounded to Q4.12.
  function automatic longint heading_q12(longint x0, longint y0);
    longint x, y, z, xn, h;
    x = x0 * 65536;
    y = y0 * 65536;
    z = 0;
    if (x0 == 0 && y0 == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Z : -PI_Z;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z += ARCTAN_Z[i];
      end else begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ARCTAN_Z[i];
      end
      x = xn;
    end
    h = z - HALF_PI_Z;
    if (x0 < 0) begin
      if (h < 0) h += TWO_PI_Z;
      if (h < 0) h = 0;
      if (h > PI_Z) h = PI_Z;
    end else begin
      h += TWO_PI_Z;
      if (h < PI_Z) h = PI_Z;
      if (h > TWO_PI_Z) h = TWO_PI_Z;
    end
    return (h + (64'sd1 << 17)) >>> 18;
  endfunction

  function automatic void rotate_held(longint turn);
    longint x, y, z, xn;
    x = (held_x * GAIN_Z) >>> 15;
    y = (held_y * GAIN_Z) >>> 15;
    z = turn * (64'sd1 << 18);
    while (z > PI_Z) z -= TWO_PI_Z;
    while (z <= -PI_Z) z += TWO_PI_Z;
    // fold into the CORDIC's reach by a half turn
    if (z > HALF_PI_Z) begin
      x = -x; y = -y; z -= PI_Z;
    end else if (z < -HALF_PI_Z) begin
      x = -x; y = -y; z += PI_Z;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ARCTAN_Z[i];
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z += ARCTAN_Z[i];
      end
      x = xn;
    end
    held_x = sat_coord((x + 64'sd32768) >>> 16);
    held_y = sat_coord((y + 64'sd32768) >>> 16);
  endfunction

  function automatic longint scaled_comp(longint c, longint unsigned len,
                                         longint unsigned m);
    longint unsigned ac;
    longint q;
    ac = (c < 0) ? -c : c;
    q = longint'((ac * len) / m);
    return sat_coord((c < 0) ? -q : q);
  endfunction

  // Zero-length source: keep the held vector as it is.
  function automatic void rescale_from(longint x, longint y, longint unsigned len);
    longint unsigned m;
    m = vec_length(x, y);
    if (m == 0) return;
    held_x = scaled_comp(x, len, m);
    held_y = scaled_comp(y, len, m);
  endfunction

  function automatic vec_result_t apply_request(vec_request_t r);
    vec_result_t res;
    longint ang;
    case (r.op)
      F_LOAD: begin
        held_x = r.vx;
        held_y = r.vy;
      end
      F_LOADS: begin
        held_x = 0;
        held_y = 0;
        rescale_from(r.vx, r.vy, r.len);
      end
      F_ROTATE: rotate_held(r.turn);
      F_SETLEN: rescale_from(held_x, held_y, r.len);
      default: ;
    endcase
    if (r.op == F_ANGLE) ang = heading_q12(r.vx, r.vy) - heading_q12(held_x, held_y);
    else ang = heading_q12(held_x, held_y);
    res.rx = held_x[31:0];
    res.ry = held_y[31:0];
    res.mag = 32'(vec_length(held_x, held_y));
    res.heading = ang[15:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [31:0] pick_coord();
    int k;
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 0;
      3, 4: return $urandom;
      default: begin
        // mostly moderate sizes so rescale and rotate stay in range
        k = $urandom_range(0, 30);
        return $signed($urandom & ((32'd1 << k) - 1)) * ($urandom_range(0, 1) ? 1 : -1);
      end
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(0, 32'h00FFFFFF));
    endcase
  endfunction

  function automatic vec_request_t random_request();
    vec_request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 18) r.op = F_LOAD;
    else if (pick < 32) r.op = F_LOADS;
    else if (pick < 56) r.op = F_ROTATE;
    else if (pick < 70) r.op = F_SETLEN;
    else if (pick < 86) r.op = F_ANGLE;
    else if (pick < 95) r.op = F_QUERY;
    else r.op = $urandom_range(0, 1) ? F_SPARE6 : F_SPARE7;
    r.vx = pick_coord();
    r.vy = pick_coord();
    r.len = pick_length();
    r.turn = 16'($urandom);
    return r;
  endfunction

  task automatic queue_request(logic [2:0] op, logic signed [31:0] vx,
                               logic signed [31:0] vy, logic [LEN_W-1:0] len,
                               logic signed [15:0] turn);
    vec_request_t r;
    r.op = op; r.vx = vx; r.vy = vy; r.len = len; r.turn = turn;
    pending_requests.push_back(r);
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      // hold an offered request until it is taken
      if (!in_valid || request_taken) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          vec_request_t r;
          r = pending_requests.pop_front();
          in_valid <= 1'b1;
          func <= r.op;
          in_x <= r.vx;
          in_y <= r.vy;
          target_length <= r.len;
          turn_angle <= r.turn;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    request_taken <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        vec_request_t r;
        r.op = func; r.vx = in_x; r.vy = in_y; r.len = target_length; r.turn = turn_angle;
        op_count[func]++;
        expected_results.push_back(apply_request(r));
      end
      if (out_valid && out_ready) begin
        vec_result_t want;
        result_count++;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("ERROR at %0t: result with no request outstanding", $realtime);
        end else begin
          want = expected_results.pop_front();
          if (out_x !== want.rx) report_mismatch("out_x", out_x, want.rx);
          if (out_y !== want.ry) report_mismatch("out_y", out_y, want.ry);
          if (magnitude !== want.mag) report_mismatch("magnitude", magnitude, want.mag);
          if (angle_out !== want.heading)
            report_mismatch("angle_out", 32'(angle_out), 32'(want.heading));
        end
      end
      // watchdog: stop if nothing moves for too long
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    func = F_QUERY;
    in_x = 0;
    in_y = 0;
    target_length = 0;
    turn_angle = 0;
    request_taken = 1'b0;
    held_x = 0;
    held_y = 0;
    error_count = 0;
    result_count = 0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opener: reset state, zero vectors, extremes, every code.
    queue_request(F_QUERY, 0, 0, 0, 0);
    queue_request(F_SETLEN, 0, 0, 31'h7FFFFFFF, 0);          // zero held vector
    queue_request(F_LOADS, 0, 0, 31'h00010000, 0);           // zero input
    queue_request(F_ANGLE, 0, 0, 0, 0);
    queue_request(F_LOAD, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0);  // largest positive vector
    queue_request(F_ROTATE, 0, 0, 0, 16'sh7FFF);
    queue_request(F_LOAD, 32'sh80000000, 32'sh80000000, 0, 0);
    queue_request(F_ROTATE, 0, 0, 0, 16'sh8000);
    queue_request(F_LOAD, 32'sh40000000, 0, 0, 0);
    queue_request(F_ROTATE, 0, 0, 0, 16'sd6434);                // about pi/2 up
    queue_request(F_ROTATE, 0, 0, 0, 16'sd12868);               // about pi
    queue_request(F_ROTATE, 0, 0, 0, -16'sd6434);
    queue_request(F_LOAD, 0, -32'sd65536, 0, 0);                 // straight down
    queue_request(F_LOAD, -32'sd65536, 0, 0, 0);
    queue_request(F_SETLEN, 0, 0, 31'h7FFFFFFF, 0);
    queue_request(F_SETLEN, 0, 0, 0, 0);
    queue_request(F_LOADS, 32'sh80000000, 32'sd1, 31'h7FFFFFFF, 0);
    queue_request(F_ANGLE, 32'sh7FFFFFFF, 32'sh80000000, 0, 0);
    queue_request(F_ANGLE, -32'sd1, 32'sd1, 0, 0);
    queue_request(F_LOAD, 32'sd3, -32'sd4, 0, 0);
    queue_request(F_SPARE6, 32'sd5, 32'sd5, 31'h1234, 16'sd99);
    queue_request(F_SPARE7, -32'sd5, 32'sd5, 31'h1234, 16'sd99);
    queue_request(F_QUERY, 32'sh7FFFFFFF, 0, 31'h7FFFFFFF, 16'sh7FFF);
    drain();

    // Random phases: free flow, slow sender, slow receiver, light jitter.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
        default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) pending_requests.push_back(random_request());
      drain();
    end

    repeat (300) @(posedge clk);
    $display("Covered %0d results: load %0d, load-scaled %0d, rotate %0d, set-length %0d,",
             result_count, op_count[F_LOAD], op_count[F_LOADS], op_count[F_ROTATE],
             op_count[F_SETLEN]);
    $display("  angle %0d, query %0d, spare codes %0d; %0d mismatches",
             op_count[F_ANGLE], op_count[F_QUERY], op_count[F_SPARE6] + op_count[F_SPARE7],
             error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
